// ===== rtl/core/twi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_pkg
// Shared types, constants and helpers for the letter trie builder.
// ----------------------------------------------------------------------------
package twi_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LETTERS    = 26;
	localparam int CASE_GAP   = 32;
	localparam int DEPTH      = MAX_NODES * LETTERS;
	localparam int NODE_W     = 10;
	localparam int COUNT_W    = 11;
	localparam int LETTER_W   = 5;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int ENTRY_W    = 12;

	// input modes
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_END  = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// entry marks
	localparam logic [1:0] MARK_NONE    = 2'd0;
	localparam logic [1:0] MARK_FOLLOWS = 2'd1;
	localparam logic [1:0] MARK_END     = 2'd2;

	typedef enum logic [1:0] {
		OP_LETTER,
		OP_CLOSE,
		OP_READ,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [LETTER_W-1:0]   letter;
		logic [NODE_W-1:0]     node;
	} op_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_LINK,
		B_CUR,
		B_RESP
	} back_state_t;

	// table address of one entry: node * 26 + letter, by shifts and adds
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [NODE_W-1:0] node,
							input logic [LETTER_W-1:0] letter);
		logic [ADDR_W-1:0] n;
		n = ADDR_W'(node);
		return (n << 4) + (n << 3) + (n << 1) + ADDR_W'(letter);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/twi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_in_if / twi_out_if
// Valid/ready channels for text items and for results.
// ----------------------------------------------------------------------------
interface twi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  text_byte;
	logic [9:0]  read_node;
	logic [4:0]  read_letter;

	modport source (output valid, mode, text_byte, read_node, read_letter, input ready);
	modport sink   (input valid, mode, text_byte, read_node, read_letter, output ready);
endinterface

interface twi_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] nodes_used;
	logic        table_overflow;
	logic [1:0]  entry_mark;
	logic [9:0]  entry_child;

	modport source (output valid, nodes_used, table_overflow, entry_mark, entry_child,
			input ready);
	modport sink   (input valid, nodes_used, table_overflow, entry_mark, entry_child,
			output ready);
endinterface
`default_nettype wire

// ===== rtl/core/twi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_front
// Accepts input items and classifies them into trie operations.
// ----------------------------------------------------------------------------
module twi_front
	import twi_pkg::*;
(
	twi_in_if.sink         in,
	input  logic           q_ready,
	output logic           q_push,
	output op_t            q_op
);

	logic [7:0] lc;
	logic       is_lower;
	logic       is_upper;

	assign in.ready = q_ready;
	assign q_push   = in.valid & q_ready;

	// fold case and sort the item
	always_comb begin
		is_lower = (in.text_byte >= 8'(int'("a"))) && (in.text_byte <= 8'(int'("z")));
		is_upper = (in.text_byte >= 8'(int'("A"))) && (in.text_byte <= 8'(int'("Z")));
		lc       = is_upper ? in.text_byte + 8'(CASE_GAP) : in.text_byte;
		q_op.letter = LETTER_W'(lc - 8'(int'("a")));
		q_op.node   = in.read_node;
		unique case (in.mode)
			MODE_TEXT: q_op.kind = (is_lower || is_upper) ? OP_LETTER : OP_CLOSE;
			MODE_END:  q_op.kind = OP_CLOSE;
			MODE_READ: begin
				q_op.kind   = ((32'(in.read_letter) < LETTERS) &&
					       (32'(in.read_node) < MAX_NODES)) ? OP_READ : OP_NOP;
				q_op.letter = in.read_letter;
			end
			default:   q_op.kind = OP_NOP;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/twi_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_queue
// Two-entry operation queue between the front and the back.
// ----------------------------------------------------------------------------
module twi_queue
	import twi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic push_ready,
	input  logic pop,
	output logic pop_valid,
	output op_t  pop_op
);

	op_t        buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_op     = buf_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= push_op;
	end

endmodule
`default_nettype wire

// ===== rtl/core/twi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_back
// Carries out trie operations on the node table and issues results.
// ----------------------------------------------------------------------------
module twi_back
	import twi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	input  op_t       op_in,
	output logic      op_pop,
	twi_out_if.source out
);

	back_state_t          state_q, state_d;
	logic [ENTRY_W-1:0]   mem [DEPTH];
	logic [ENTRY_W-1:0]   rd_q;
	logic [ADDR_W-1:0]    clr_q;
	op_t                  op_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 ovf_q, inside_q, drop_q;
	logic [NODE_W-1:0]    last_node_q, cur_node_q;
	logic [LETTER_W-1:0]  last_letter_q;
	logic [1:0]           last_mark_q;
	logic [NODE_W-1:0]    last_child_q;
	logic [1:0]           emark_q;
	logic [NODE_W-1:0]    echild_q;
	logic                 need_alloc, full;
	logic                 we, re;
	logic [ADDR_W-1:0]    addr;
	logic [ENTRY_W-1:0]   wdata;
	logic                 out_free;
	logic [1:0]           rd_mark;

	assign need_alloc = (last_child_q == '0);
	assign full       = (count_q == COUNT_W'(MAX_NODES));
	assign out_free   = !out.valid || out.ready;
	assign op_pop     = (state_q == B_IDLE) && op_valid;
	assign rd_mark    = rd_q[ENTRY_W-1 -: 2];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = B_IDLE;
			B_IDLE: begin
				if (op_valid) begin
					unique case (op_in.kind)
						OP_LETTER: begin
							if (drop_q)                  state_d = B_RESP;
							else if (!inside_q)          state_d = B_CUR;
							else if (!need_alloc)        state_d = B_CUR;
							else if (full)               state_d = B_RESP;
							else                         state_d = B_LINK;
						end
						OP_READ:  state_d = B_CUR;
						default:  state_d = B_RESP;
					endcase
				end
			end
			B_LINK:  state_d = B_CUR;
			B_CUR:   state_d = B_RESP;
			B_RESP:  if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		addr  = slot_addr(cur_node_q, op_q.letter);
		wdata = '0;
		unique case (state_q)
			B_CLEAR: begin
				we   = 1'b1;
				addr = clr_q;
			end
			B_IDLE: begin
				if (op_valid) begin
					unique case (op_in.kind)
						OP_LETTER: begin
							if (!drop_q && !inside_q) begin
								re   = 1'b1;
								addr = slot_addr('0, op_in.letter);
							end else if (!drop_q && !need_alloc) begin
								re   = 1'b1;
								addr = slot_addr(last_child_q, op_in.letter);
							end else if (!drop_q && !full) begin
								// link a fresh node under the previous entry
								we    = 1'b1;
								addr  = slot_addr(last_node_q, last_letter_q);
								wdata = {last_mark_q, count_q[NODE_W-1:0]};
							end
						end
						OP_CLOSE: begin
							if (inside_q && !drop_q) begin
								we    = 1'b1;
								addr  = slot_addr(last_node_q, last_letter_q);
								wdata = {MARK_END, last_child_q};
							end
						end
						OP_READ: begin
							re   = 1'b1;
							addr = slot_addr(op_in.node, op_in.letter);
						end
						default: ;
					endcase
				end
			end
			B_LINK: re = 1'b1;
			B_CUR: begin
				if (op_q.kind == OP_LETTER && rd_mark == MARK_NONE) begin
					we    = 1'b1;
					wdata = {MARK_FOLLOWS, rd_q[NODE_W-1:0]};
				end
			end
			default: ;
		endcase
	end

	// node table
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rd_q <= mem[addr];
	end

	// control and word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			inside_q     <= 1'b0;
			drop_q       <= 1'b0;
			last_node_q  <= '0;
			last_letter_q<= '0;
			last_mark_q  <= MARK_NONE;
			last_child_q <= '0;
			out.valid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			// result offered from the response state, withdrawn once taken
			if (state_q == B_RESP && out_free) out.valid <= 1'b1;
			else if (out.valid && out.ready)   out.valid <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (op_valid) begin
						unique case (op_in.kind)
							OP_LETTER: begin
								if (!drop_q && !inside_q) begin
									if (count_q == '0) count_q <= COUNT_W'(1);
								end else if (!drop_q && need_alloc) begin
									if (full) begin
										ovf_q  <= 1'b1;
										drop_q <= 1'b1;
									end else begin
										count_q <= count_q + 1'b1;
									end
								end
							end
							OP_CLOSE: begin
								inside_q <= 1'b0;
								drop_q   <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				B_CUR: begin
					if (op_q.kind == OP_LETTER) begin
						inside_q      <= 1'b1;
						last_node_q   <= cur_node_q;
						last_letter_q <= op_q.letter;
						last_mark_q   <= (rd_mark == MARK_NONE) ? MARK_FOLLOWS : rd_mark;
						last_child_q  <= rd_q[NODE_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q     <= op_in;
			emark_q  <= MARK_NONE;
			echild_q <= '0;
			if (!inside_q)        cur_node_q <= '0;
			else if (!need_alloc) cur_node_q <= last_child_q;
			else                  cur_node_q <= count_q[NODE_W-1:0];
		end
		if (state_q == B_CUR && op_q.kind == OP_READ) begin
			emark_q  <= rd_mark;
			echild_q <= rd_q[NODE_W-1:0];
		end
		if (state_q == B_RESP && out_free) begin
			out.nodes_used     <= count_q;
			out.table_overflow <= ovf_q;
			out.entry_mark     <= emark_q;
			out.entry_child    <= echild_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/trie_word_insert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trie_word_insert
// Builds a 26-way letter trie from a text byte stream; one result per item.
// ----------------------------------------------------------------------------
// Items move from the idle state to the response state: close and no-op items
// and dropped letters directly, a read or a letter through the current-entry
// state, and a letter that allocates a node through the link state first.
// One item at a time on the single table port; a new item is taken only once
// the last result is offered. Reset: control state clears at once; the node
// table is then swept to zero, during which items queue but none is processed.
module trie_word_insert
	import twi_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	twi_in_if.sink    in,
	twi_out_if.source out
);

	logic q_push, q_ready, q_pop, q_valid;
	op_t  q_in_op, q_out_op;

	twi_front u_front (
		.in      (in),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_op    (q_in_op)
	);

	twi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_in_op),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_op     (q_out_op)
	);

	twi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op_in    (q_out_op),
		.op_pop   (q_pop),
		.out      (out)
	);

endmodule
`default_nettype wire

// ===== rtl/core/twi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_checker
// Port-level checks on the trie builder, bound to the top level.
// ----------------------------------------------------------------------------
module twi_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [10:0] nodes_used,
	input wire        table_overflow,
	input wire [1:0]  entry_mark
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// node count never goes down between results
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> nodes_used >= $past(nodes_used))
		else $error("node count decreased");

	// overflow is sticky
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && $past(table_overflow) |-> table_overflow)
		else $error("overflow flag cleared");

	// counts and marks stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nodes_used <= 11'd1024 && entry_mark != 2'd3)
		else $error("result field out of range");

endmodule

bind trie_word_insert twi_checker u_twi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.nodes_used     (out.nodes_used),
	.table_overflow (out.table_overflow),
	.entry_mark     (out.entry_mark)
);
`default_nettype wire
